>>> src/s512_pkg.sv
// shared types, constants and round functions for the sha-512 digest block
package s512_pkg;

  localparam int WordW    = 64;
  localparam int Rounds   = 80;
  localparam int BlkWords = 16;
  localparam int QDepth   = 8;
  localparam int QPtrW    = $clog2(QDepth);

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t word;
    logic  fin;
    logic  tl;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_BYTES,
    F_PAD,
    F_ZERO
  } front_state_t;

  typedef enum logic [1:0] {
    B_RND,
    B_ADD,
    B_OUT
  } back_state_t;

  localparam word_t InitHash [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
    64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

  localparam word_t RoundK [Rounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
    64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
    64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
    64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
    64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
    64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
    64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
    64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
    64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
    64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
    64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
    64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
    64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
    64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
    64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
    64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
    64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
    64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
    64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
    64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
    64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

endpackage

>>> src/s512_front.sv
// byte packer, bit counter and padding sequencer feeding the word queue
module s512_front
  import s512_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_din
);

  front_state_t state_r, state_nxt;
  word_t        acc_r, acc_nxt;
  logic [2:0]   bpos_r, bpos_nxt;
  logic [3:0]   wi_r, wi_nxt;
  word_t        bits_r, bits_nxt;
  logic         wrap_r, wrap_nxt;
  logic         lenok_r, lenok_nxt;
  logic         acc_take;
  logic [64:0]  bits_sum;
  logic [6:0]   sh_acc;
  logic [5:0]   sh_mark;
  word_t        pad_word;
  word_t        byte_word;
  logic         is_fin;

  assign acc_take  = in_valid && !in_stall;
  assign bits_sum  = {1'b0, bits_r} + 65'd8;
  assign sh_acc    = 7'd64 - {1'b0, bpos_r, 3'b000};
  assign sh_mark   = {~bpos_r, 3'b000};
  assign pad_word  = (acc_r << sh_acc) | (word_t'(8'h80) << sh_mark);
  assign byte_word = {acc_r[55:0], in_data_byte};
  assign is_fin    = lenok_r && (wi_r == 4'd15);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_BYTES: if (acc_take && in_last) state_nxt = F_PAD;
      F_PAD:   if (!q_full) state_nxt = F_ZERO;
      F_ZERO:  if (!q_full && is_fin) state_nxt = F_BYTES;
      default: state_nxt = F_BYTES;
    endcase
  end

  always_comb begin
    in_stall  = q_full || (state_r != F_BYTES);
    q_push    = 1'b0;
    q_din     = '{word: byte_word, fin: 1'b0, tl: wrap_r};
    acc_nxt   = acc_r;
    bpos_nxt  = bpos_r;
    wi_nxt    = wi_r;
    bits_nxt  = bits_r;
    wrap_nxt  = wrap_r;
    lenok_nxt = lenok_r;
    unique case (state_r)
      F_BYTES: begin
        if (acc_take && in_byte_present) begin
          acc_nxt  = byte_word;
          bpos_nxt = bpos_r + 3'd1;
          bits_nxt = bits_sum[63:0];
          wrap_nxt = wrap_r | bits_sum[64];
          if (bpos_r == 3'd7) begin
            q_push = 1'b1;
            wi_nxt = wi_r + 4'd1;
          end
        end
      end
      F_PAD: begin
        q_din.word = pad_word;
        if (!q_full) begin
          q_push    = 1'b1;
          wi_nxt    = wi_r + 4'd1;
          bpos_nxt  = 3'd0;
          lenok_nxt = (wi_r != 4'd14);
        end
      end
      F_ZERO: begin
        q_din.word = is_fin ? bits_r : '0;
        q_din.fin  = is_fin;
        if (!q_full) begin
          q_push = 1'b1;
          wi_nxt = wi_r + 4'd1;
          if (wi_r == 4'd15) lenok_nxt = 1'b1;
          if (is_fin) begin
            bits_nxt = '0;
            wrap_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_BYTES;
      bpos_r  <= '0;
      wi_r    <= '0;
      bits_r  <= '0;
      wrap_r  <= 1'b0;
      lenok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bpos_r  <= bpos_nxt;
      wi_r    <= wi_nxt;
      bits_r  <= bits_nxt;
      wrap_r  <= wrap_nxt;
      lenok_r <= lenok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

>>> src/s512_fifo.sv
// word queue between the packer and the compression engine
module s512_fifo
  import s512_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  output logic     full,
  input  logic     pop,
  output q_entry_t dout,
  output logic     empty
);

  q_entry_t         mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;

  assign full  = (cnt_r == (QPtrW+1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + QPtrW'(1);
      if (pop && !empty) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_r + (QPtrW+1)'(push && !full) - (QPtrW+1)'(pop && !empty);
    end
  end

endmodule

>>> src/s512_back.sv
// 80-round compression engine with chaining words and digest output
module s512_back
  import s512_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    q_dout,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_too_long
);

  back_state_t state_r, state_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [BlkWords];
  logic [6:0]  t_r;
  logic [2:0]  idx_r;
  logic        fin_r, tl_r;
  logic        adv;
  word_t       wt, wnew, p, q;

  assign adv  = (state_r == B_RND) && (t_r >= 7'd16 || !q_empty);
  assign wnew = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign wt   = (t_r < 7'd16) ? q_dout.word : wnew;
  assign p    = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + RoundK[t_r] + wt;
  assign q    = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_RND:   if (adv && t_r == 7'd79) state_nxt = B_ADD;
      B_ADD:   state_nxt = fin_r ? B_OUT : B_RND;
      B_OUT:   if (!out_stall && idx_r == 3'd7) state_nxt = B_RND;
      default: state_nxt = B_RND;
    endcase
  end

  always_comb begin
    q_pop           = adv && (t_r < 7'd16);
    out_valid       = (state_r == B_OUT);
    out_digest_word = h_r[idx_r];
    out_word_index  = idx_r;
    out_last_word   = (idx_r == 3'd7);
    out_too_long    = tl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_RND;
      t_r     <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      tl_r    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= InitHash[i];
        v_r[i] <= InitHash[i];
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        B_RND: begin
          if (adv) begin
            t_r <= (t_r == 7'd79) ? 7'd0 : t_r + 7'd1;
            if (t_r == 7'd15) begin
              fin_r <= q_dout.fin;
              tl_r  <= q_dout.tl;
            end
            v_r[0] <= p + q;
            v_r[1] <= v_r[0];
            v_r[2] <= v_r[1];
            v_r[3] <= v_r[2];
            v_r[4] <= v_r[3] + p;
            v_r[5] <= v_r[4];
            v_r[6] <= v_r[5];
            v_r[7] <= v_r[6];
          end
        end
        B_ADD: begin
          idx_r <= '0;
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
            v_r[i] <= h_r[i] + v_r[i];
          end
        end
        B_OUT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                h_r[i] <= InitHash[i];
                v_r[i] <= InitHash[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BlkWords-1] <= wt;
    end
  end

endmodule

>>> src/sha512_message_digest.sv
// top level of the byte-fed sha-512 digest block
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_data_byte, in_byte_present, in_last
//   out     | output    | out_valid, out_stall, out_digest_word, out_word_index,
//           |           | out_last_word, out_too_long
// one byte per cycle is taken while the eight-word queue has room and no padding is being emitted
// each 128-byte block passes through the single round unit (80 rounds, one add)
// a last transfer adds one or two padding blocks, then eight digest transfers
// synchronous active-low reset restores the initial hash state
// a stalled output holds the engine; the packer keeps filling the queue
module sha512_message_digest
  import s512_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_too_long
);

  q_entry_t q_din, q_dout;
  logic     q_push, q_pop, q_full, q_empty;

  s512_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_din           (q_din)
  );

  s512_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  s512_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_dout          (q_dout),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .out_too_long    (out_too_long)
  );

endmodule

>>> tb/sha512_message_digest_test.sv
// self-checking testbench for the byte-fed sha-512 digest block
`timescale 1ns / 100ps

module sha512_message_digest_test;
  import s512_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } msg_item_t;

  typedef struct {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        too_long;
  } digest_out_t;

  localparam int CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic        out_too_long;

  msg_item_t   pending_bytes[$];
  digest_out_t expected_digests[$];
  logic [7:0]  blk_bytes[128];
  logic [63:0] hash_state[8];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  logic        bits_wrapped;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  bit  sender_paused = 1'b0;
  int  errors = 0;
  int  cycles = 0;
  int  sent_count = 0;
  int  digest_count = 0;
  int  message_count = 0;

  always #5 clk = ~clk;

  sha512_message_digest dut (.*);

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_blk();
    logic [63:0] w[80];
    logic [63:0] v[8];
    logic [63:0] s0, s1, p, q, e, a;
    for (int t = 0; t < 16; t++) begin
      w[t] = '0;
      for (int b = 0; b < 8; b++) w[t] = {w[t][55:0], blk_bytes[t*8+b]};
    end
    for (int t = 16; t < 80; t++) begin
      s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
      s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int b = 0; b < 8; b++) v[b] = hash_state[b];
    for (int t = 0; t < 80; t++) begin
      e = v[4];
      a = v[0];
      p = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & v[5]) ^ (~e & v[6]))
          + RoundK[t] + w[t];
      q = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
          + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + p;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = p + q;
    end
    for (int b = 0; b < 8; b++) hash_state[b] += v[b];
  endtask

  task automatic digest_restart();
    for (int b = 0; b < 8; b++) hash_state[b] = InitHash[b];
    blk_fill = 0;
    msg_bits = '0;
    bits_wrapped = 1'b0;
  endtask

  task automatic predict_digest(input msg_item_t it);
    int unsigned pos;
    digest_out_t d;
    if (it.byte_present) begin
      blk_bytes[blk_fill] = it.data_byte;
      msg_bits += 8;
      if (msg_bits < 8) bits_wrapped = 1'b1;
      blk_fill = (blk_fill + 1) % 128;
      if (blk_fill == 0) compress_blk();
    end
    if (!it.last) return;
    pos = blk_fill;
    blk_bytes[pos++] = 8'h80;
    if (pos > 112) begin
      while (pos < 128) blk_bytes[pos++] = 8'h00;
      compress_blk();
      pos = 0;
    end
    while (pos < 120) blk_bytes[pos++] = 8'h00;
    for (int k = 0; k < 8; k++) blk_bytes[120+k] = msg_bits[56-8*k +: 8];
    compress_blk();
    for (int k = 0; k < 8; k++) begin
      d.digest_word = hash_state[k];
      d.word_index = k[2:0];
      d.last_word = (k == 7);
      d.too_long = bits_wrapped;
      expected_digests.push_back(d);
    end
    digest_restart();
  endtask

  task automatic queue_item(input logic [7:0] b, input logic p, input logic l);
    msg_item_t it;
    it.data_byte = b;
    it.byte_present = p;
    it.last = l;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_message(input int len, input bit end_empty);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_empty);
    end
    if (end_empty || len == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain_wait();
    while (pending_bytes.size() != 0 || expected_digests.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_digest(pending_bytes.pop_front());
        sent_count++;
      end
      if (in_valid && in_stall) begin
      end else if (pending_bytes.size() != 0 && !sender_paused
                   && $urandom_range(0, 99) >= send_idle_pct
                   && !(in_valid && !in_stall && pending_bytes.size() == 0)) begin
        in_valid <= 1'b1;
        in_data_byte <= pending_bytes[0].data_byte;
        in_byte_present <= pending_bytes[0].byte_present;
        in_last <= pending_bytes[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_out_t exp_d;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_digests.size() == 0) begin
          $error("unexpected digest transfer %h", out_digest_word);
          errors++;
        end else begin
          exp_d = expected_digests.pop_front();
          digest_count++;
          if (out_digest_word !== exp_d.digest_word) begin
            $error("digest_word exp %h got %h", exp_d.digest_word, out_digest_word);
            errors++;
          end
          if (out_word_index !== exp_d.word_index) begin
            $error("word_index exp %0d got %0d", exp_d.word_index, out_word_index);
            errors++;
          end
          if (out_last_word !== exp_d.last_word) begin
            $error("last_word exp %0b got %0b", exp_d.last_word, out_last_word);
            errors++;
          end
          if (out_too_long !== exp_d.too_long) begin
            $error("too_long exp %0b got %0b", exp_d.too_long, out_too_long);
            errors++;
          end
          if (out_last_word === 1'b1) message_count++;
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    digest_restart();
    for (int i = 0; i < 128; i++) blk_bytes[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, single bytes at extremes, two-block padding
    queue_item(8'h00, 1'b0, 1'b1);
    queue_item(8'hFF, 1'b1, 1'b1);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'hA5, 1'b0, 1'b0);
    queue_item(8'h5A, 1'b1, 1'b0);
    queue_item(8'h3C, 1'b0, 1'b1);
    queue_message(112, 1'b0);
    drain_wait();

    // random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 73 : 16) : 0;
      recv_stall_pct = (ph == 2) ? 73 : ((ph == 3) ? 16 : 0);
      for (int m = 0; m < 2; m++) begin
        if ($urandom_range(0, 3) == 0) queue_message($urandom_range(0, 3),
                                                     1'($urandom_range(0, 1)));
        else queue_message($urandom_range(1, 10), 1'($urandom_range(0, 1)));
      end
      if (ph == 0) begin
        hold_off_cycles = 3000;
        while (pending_bytes.size() != 0) @(posedge clk);
        // pause the sender until every digest has come out
        sender_paused = 1'b1;
        queue_message(5, 1'b0);
        while (expected_digests.size() != 0) @(posedge clk);
        sender_paused = 1'b0;
      end
      drain_wait();
    end

    repeat (400) @(posedge clk);
    $display("sent %0d byte transfers, checked %0d digest words in %0d messages",
             sent_count, digest_count, message_count);
    $display("covered empty and boundary messages, idle and stall mixes, long hold-off");
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
